/* rtl/text_console_cell_writer_unit_defines.svh */
// assertion macros shared by the checker
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH

// checked only outside reset
`define TCCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define TCCW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tccw_pkg.sv */
package tccw_pkg;

  typedef enum logic [1:0] {
    ACT_CHAR    = 2'd0,
    ACT_REFRESH = 2'd1,
    ACT_ATTR    = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  char_code;
    logic [7:0]  attribute_code;
    logic [10:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_cell;
    logic        bell;
    logic [7:0]  current_attribute;
    logic [7:0]  read_char;
    logic [7:0]  read_attribute;
  } result_t;

  localparam logic [7:0] CH_BELL    = 8'd7;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  localparam logic [7:0] RESET_ATTR = 8'h07;
  localparam logic [7:0] KEEP_MASK  = 8'h88;
  localparam logic [7:0] FG_MASK    = 8'h07;
  localparam logic [7:0] BG_MASK    = 8'h70;
  localparam logic [7:0] BOLD_BIT   = 8'h08;

  localparam logic [7:0] SGR_RESET   = 8'd0;
  localparam logic [7:0] SGR_BOLD    = 8'd1;
  localparam logic [7:0] SGR_REVERSE = 8'd7;
  localparam logic [7:0] SGR_FG_LO   = 8'd30;
  localparam logic [7:0] SGR_FG_HI   = 8'd37;
  localparam logic [7:0] SGR_BG_LO   = 8'd40;
  localparam logic [7:0] SGR_BG_HI   = 8'd47;

  localparam logic [2:0] SGR_COLOUR_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6,
                                                3'd1, 3'd5, 3'd3, 3'd7};

  function automatic logic [7:0] sgr_apply(logic [7:0] a, logic [7:0] code);
    logic [7:0] r;
    logic [7:0] fg_sel;
    logic [7:0] bg_sel;
    r = a;
    fg_sel = code - SGR_FG_LO;
    bg_sel = code - SGR_BG_LO;
    case (code) inside
      SGR_RESET:   r = RESET_ATTR;
      SGR_BOLD:    r = a | BOLD_BIT;
      SGR_REVERSE: r = (a & KEEP_MASK) | ((a & FG_MASK) << 4) | ((a & BG_MASK) >> 4);
      [SGR_FG_LO:SGR_FG_HI]:
        r = (a & ~FG_MASK) | {5'b0, SGR_COLOUR_MAP[fg_sel[2:0]]};
      [SGR_BG_LO:SGR_BG_HI]:
        r = (a & ~BG_MASK) | {1'b0, SGR_COLOUR_MAP[bg_sel[2:0]], 4'b0};
      default:     r = a;
    endcase
    return r;
  endfunction

endpackage

/* rtl/tccw_ram.sv */
module tccw_ram #(
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/text_console_cell_writer_unit.sv */
// text console cell writer
// item channel (item_valid/item_ready/item) takes one beat per command: a character,
// a cursor refresh, an SGR attribute code or a cell read. result channel
// (result_valid/result_ready/result) returns exactly one beat per command with the
// cursor, the current attribute, the bell flag and the cell read back.
// one command is worked at a time; item_ready is high only while the sequencer idles.
// a character that moves past the last row scrolls: a scan counter walks the screen
// memory copying one cell per cycle and then blanks the bottom row.
// after reset the screen memory is cleared to blank cells with attribute 0x07
// while item_ready stays low; the cursor goes to the top left and the attribute
// to 0x07.
// the result sits in an output register; a stalled receiver holds it there while the
// next command is accepted and worked, and only its result waits for the register.
module text_console_cell_writer_unit #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tccw_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output tccw_pkg::result_t result
);
  import tccw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int LW     = AW + 1;
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int PW     = $clog2(TAB_WIDTH);
  localparam int XW     = CW + 5;
  localparam int IW     = (AW + 1 > 11) ? AW + 1 : 11;
  localparam int BOTTOM = COLUMNS * (ROWS - 1);
  localparam int LAST_COL_PHASE = (COLUMNS - 1) % TAB_WIDTH;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_READ   = 7'b0001000,
    ST_SCROLL = 7'b0010000,
    ST_BLANK  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t        state;
  item_t         op;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [PW-1:0] phase;
  logic [AW-1:0] lin;
  logic [7:0]    attr;
  logic          bell_r;
  logic [7:0]    rch;
  logic [7:0]    rat;
  logic [AW-1:0] scan;
  logic          pend;
  logic [AW-1:0] pend_addr;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;

  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [PW-1:0] phase_next;
  logic [AW-1:0] lin_next;
  logic          bell_next;
  logic          scroll;
  logic          cw_en;
  logic [AW-1:0] cw_addr;
  logic [7:0]    cw_char;
  logic          adv;
  logic [LW-1:0] line_start;
  logic [XW-1:0] tab_col;
  logic          in_range;

  tccw_ram #(.DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign item_ready = (state == ST_IDLE);
  assign in_range   = IW'(op.cell_index) < IW'(CELLS);
  assign line_start = LW'(lin) - LW'(col);
  assign tab_col    = XW'(col) + XW'(TAB_WIDTH) - XW'(phase);

  // cursor and cell effect of one character
  always_comb begin
    col_next   = col;
    row_next   = row;
    phase_next = phase;
    lin_next   = lin;
    bell_next  = 1'b0;
    scroll     = 1'b0;
    cw_en      = 1'b0;
    cw_addr    = lin;
    cw_char    = op.char_code;
    adv        = 1'b0;
    case (op.char_code)
      CH_BELL: begin
        bell_next = 1'b1;
      end
      CH_CR: begin
        col_next   = '0;
        phase_next = '0;
        lin_next   = AW'(line_start);
      end
      CH_LF: begin
        adv = 1'b1;
      end
      CH_BS: begin
        if (col != '0) begin
          col_next   = col - CW'(1);
          phase_next = (phase == '0) ? PW'(TAB_WIDTH - 1) : phase - PW'(1);
          lin_next   = lin - AW'(1);
          cw_en      = 1'b1;
          cw_addr    = lin - AW'(1);
          cw_char    = BLANK_CHAR;
        end else if (row != '0) begin
          row_next   = row - RW'(1);
          col_next   = CW'(COLUMNS - 1);
          phase_next = PW'(LAST_COL_PHASE);
          lin_next   = lin - AW'(1);
          cw_en      = 1'b1;
          cw_addr    = lin - AW'(1);
          cw_char    = BLANK_CHAR;
        end
      end
      CH_TAB: begin
        if (tab_col >= XW'(COLUMNS)) begin
          adv = 1'b1;
        end else begin
          col_next   = CW'(tab_col);
          phase_next = '0;
          lin_next   = AW'(LW'(lin) + LW'(TAB_WIDTH) - LW'(phase));
        end
      end
      default: begin
        cw_en = 1'b1;
        if (col == CW'(COLUMNS - 1)) begin
          adv = 1'b1;
        end else begin
          col_next   = col + CW'(1);
          phase_next = (phase == PW'(TAB_WIDTH - 1)) ? '0 : phase + PW'(1);
          lin_next   = lin + AW'(1);
        end
      end
    endcase
    if (adv) begin
      col_next   = '0;
      phase_next = '0;
      if (row == RW'(ROWS - 1)) begin
        scroll   = 1'b1;
        row_next = RW'(ROWS - 1);
        lin_next = AW'(BOTTOM);
      end else begin
        row_next = row + RW'(1);
        lin_next = AW'(line_start + LW'(COLUMNS));
      end
    end
  end

  // screen memory port
  always_comb begin
    we    = 1'b0;
    waddr = scan;
    wdata = {attr, BLANK_CHAR};
    raddr = AW'(op.cell_index);
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = {RESET_ATTR, BLANK_CHAR};
      end
      ST_EXEC: begin
        we    = (op.action == ACT_CHAR) && cw_en;
        waddr = cw_addr;
        wdata = {attr, cw_char};
      end
      ST_SCROLL: begin
        raddr = AW'(LW'(scan) + LW'(COLUMNS));
        we    = pend;
        waddr = pend_addr;
        wdata = rdata;
      end
      ST_BLANK: begin
        we = 1'b1;
        if (pend) begin
          waddr = pend_addr;
          wdata = rdata;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      scan         <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
      col          <= '0;
      row          <= '0;
      phase        <= '0;
      lin          <= '0;
      attr         <= RESET_ATTR;
    end else begin
      if (result_valid && result_ready && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (scan == AW'(CELLS - 1)) begin
            scan  <= '0;
            state <= ST_IDLE;
          end else begin
            scan <= scan + AW'(1);
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            op    <= item;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          bell_r <= (op.action == ACT_CHAR) && bell_next;
          rch    <= '0;
          rat    <= '0;
          case (op.action)
            ACT_CHAR: begin
              col   <= col_next;
              row   <= row_next;
              phase <= phase_next;
              lin   <= lin_next;
              if (scroll) begin
                scan  <= '0;
                state <= ST_SCROLL;
              end else begin
                state <= ST_DONE;
              end
            end
            ACT_ATTR: begin
              attr  <= sgr_apply(attr, op.attribute_code);
              state <= ST_DONE;
            end
            ACT_READ: begin
              if (in_range) begin
                state <= ST_READ;
              end else begin
                state <= ST_DONE;
              end
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_READ: begin
          rch   <= rdata[7:0];
          rat   <= rdata[15:8];
          state <= ST_DONE;
        end
        ST_SCROLL: begin
          pend      <= 1'b1;
          pend_addr <= scan;
          if (scan == AW'(BOTTOM - 1)) begin
            scan  <= AW'(BOTTOM);
            state <= ST_BLANK;
          end else begin
            scan <= scan + AW'(1);
          end
        end
        ST_BLANK: begin
          if (pend) begin
            pend <= 1'b0;
          end else if (scan == AW'(CELLS - 1)) begin
            state <= ST_DONE;
          end else begin
            scan <= scan + AW'(1);
          end
        end
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!result_valid || result_ready)) begin
      result.cursor_col        <= 7'(col);
      result.cursor_row        <= 5'(row);
      result.cursor_cell       <= 11'(lin);
      result.bell              <= bell_r;
      result.current_attribute <= attr;
      result.read_char         <= rch;
      result.read_attribute    <= rat;
    end
  end

endmodule

/* rtl/tccw_checker.sv */
`include "text_console_cell_writer_unit_defines.svh"

module tccw_checker #(
  parameter int ROWS = 25
) (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input tccw_pkg::result_t result
);
  import tccw_pkg::*;

  // no result and no intake right out of reset
  `TCCW_ASSERT_ALWAYS(a_reset_quiet, rst |=> !result_valid && !item_ready, "active after reset")

  // one command at a time
  `TCCW_ASSERT(a_one_beat, item_valid && item_ready |=> !item_ready, "second beat taken too early")

  // stalled result holds
  `TCCW_ASSERT(a_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result dropped under stall")

  // cursor row stays on screen
  `TCCW_ASSERT(a_row_range, result_valid |-> result.cursor_row < ROWS, "cursor row off screen")

endmodule

bind text_console_cell_writer_unit tccw_checker #(.ROWS(ROWS)) u_tccw_checker (.*);

/* tb/text_console_cell_writer_unit_test.sv */
module text_console_cell_writer_unit_test;
  import tccw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TAB_WIDTH   = 8;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int ITEM_W      = $bits(item_t);
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 12000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  bit          idling_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;

  // console model
  logic [15:0] screen_model [CELLS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  cur_attr;

  result_t     expected_results [$];
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned scroll_count = 0;
  int unsigned read_count = 0;
  int unsigned bell_count = 0;

  text_console_cell_writer_unit #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always #5 clk = ~clk;

  function automatic void put_cell(logic [7:0] ch);
    screen_model[cur_row * COLUMNS + cur_col] = {cur_attr, ch};
  endfunction

  function automatic void start_next_line();
    cur_col = 0;
    cur_row++;
  endfunction

  function automatic logic apply_char(logic [7:0] ch);
    int i;
    case (ch)
      CH_BELL: return 1'b1;
      CH_CR: cur_col = 0;
      CH_LF: start_next_line();
      CH_BS: begin
        if (cur_col > 0) begin
          cur_col--;
          put_cell(BLANK_CHAR);
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLUMNS - 1;
          put_cell(BLANK_CHAR);
        end
      end
      CH_TAB: begin
        cur_col = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
        if (cur_col >= COLUMNS) start_next_line();
      end
      default: begin
        put_cell(ch);
        cur_col++;
        if (cur_col >= COLUMNS) start_next_line();
      end
    endcase
    if (cur_row >= ROWS) begin
      for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      cur_row = ROWS - 1;
      for (cur_col = 0; cur_col < COLUMNS; cur_col++) put_cell(BLANK_CHAR);
      cur_col = 0;
      scroll_count++;
    end
    return 1'b0;
  endfunction

  // ansi colour order is the bit reverse of the vga one
  function automatic logic [7:0] apply_sgr(logic [7:0] a, logic [7:0] code);
    logic [2:0] c;
    if (code == SGR_RESET) return RESET_ATTR;
    if (code == SGR_BOLD) return a | BOLD_BIT;
    if (code == SGR_REVERSE) return {a[7], a[2:0], a[3], a[6:4]};
    if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      c = 3'(code - SGR_FG_LO);
      return {a[7:3], c[0], c[1], c[2]};
    end
    if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      c = 3'(code - SGR_BG_LO);
      return {a[7], c[0], c[1], c[2], a[3:0]};
    end
    return a;
  endfunction

  function automatic result_t predict_console_step(item_t it);
    result_t r;
    r = '0;
    case (it.action)
      ACT_CHAR: begin
        r.bell = apply_char(it.char_code);
        if (r.bell) bell_count++;
      end
      ACT_ATTR: cur_attr = apply_sgr(cur_attr, it.attribute_code);
      ACT_READ: begin
        if (it.cell_index < CELLS) begin
          r.read_char      = screen_model[it.cell_index][7:0];
          r.read_attribute = screen_model[it.cell_index][15:8];
          read_count++;
        end
      end
      default: ;
    endcase
    r.cursor_col        = 7'(cur_col);
    r.cursor_row        = 5'(cur_row);
    r.cursor_cell       = 11'(cur_row * COLUMNS + cur_col);
    r.current_attribute = cur_attr;
    return r;
  endfunction

  // fields the action ignores are left random
  function automatic item_t make_item(action_t act, logic [10:0] value);
    logic [ITEM_W-1:0] raw;
    item_t it;
    raw = ITEM_W'($urandom());
    it = raw;
    it.action = act;
    case (act)
      ACT_CHAR: it.char_code = value[7:0];
      ACT_ATTR: it.attribute_code = value[7:0];
      ACT_READ: it.cell_index = value;
      default: ;
    endcase
    return it;
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(32, 126));
    if (r < 70) return 8'($urandom_range(0, 255));
    if (r < 80) return CH_TAB;
    if (r < 88) return CH_LF;
    if (r < 92) return CH_CR;
    if (r < 97) return CH_BS;
    return CH_BELL;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("beat %0d %s is %0d, expected %0d",
                                results_checked, name, got_v, want_v));
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result beat %0d with nothing expected", results_checked));
    end else begin
      want = expected_results.pop_front();
      compare_field("cursor_col", 32'(got.cursor_col), 32'(want.cursor_col));
      compare_field("cursor_row", 32'(got.cursor_row), 32'(want.cursor_row));
      compare_field("cursor_cell", 32'(got.cursor_cell), 32'(want.cursor_cell));
      compare_field("bell", 32'(got.bell), 32'(want.bell));
      compare_field("current_attribute", 32'(got.current_attribute),
                    32'(want.current_attribute));
      compare_field("read_char", 32'(got.read_char), 32'(want.read_char));
      compare_field("read_attribute", 32'(got.read_attribute), 32'(want.read_attribute));
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) check_result(result);
  end

  initial begin : result_sink
    int unsigned gap;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ready <= 1'b0;
      end else if (hold_requests != holds_served) begin
        result_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        holds_served <= holds_served + 1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        gap = $urandom_range(1, 19);
        repeat (gap - 1) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("text_console_cell_writer_unit_test NOT OK");
    $finish;
  end

  task automatic send_item(item_t it);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    expected_results.push_back(predict_console_step(it));
    items_sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_screen();
    send_item(make_item(ACT_READ, 11'd0));
    send_item(make_item(ACT_READ, 11'(CELLS - 1)));
    send_item(make_item(ACT_READ, 11'(CELLS)));
    send_item(make_item(ACT_READ, 11'h7ff));
  endtask

  task automatic test_attribute_codes();
    send_item(make_item(ACT_ATTR, 11'(SGR_BOLD)));
    send_item(make_item(ACT_ATTR, 11'(SGR_REVERSE)));
    send_item(make_item(ACT_ATTR, 11'(SGR_FG_LO)));
    send_item(make_item(ACT_ATTR, 11'(SGR_FG_HI)));
    send_item(make_item(ACT_ATTR, 11'(SGR_BG_LO)));
    send_item(make_item(ACT_ATTR, 11'(SGR_BG_HI)));
    send_item(make_item(ACT_ATTR, 11'd255));
    send_item(make_item(ACT_ATTR, 11'(SGR_RESET)));
    send_item(make_item(ACT_ATTR, 11'(SGR_BG_LO + 5)));
  endtask

  task automatic test_control_chars();
    send_item(make_item(ACT_CHAR, 11'h00));
    send_item(make_item(ACT_CHAR, 11'hff));
    send_item(make_item(ACT_CHAR, 11'(CH_BS)));
    send_item(make_item(ACT_CHAR, 11'(CH_BS)));
    // backspace at top left
    send_item(make_item(ACT_CHAR, 11'(CH_BS)));
    send_item(make_item(ACT_CHAR, 11'(CH_BELL)));
    send_item(make_item(ACT_CHAR, 11'(CH_LF)));
    // backspace back onto the previous row
    send_item(make_item(ACT_CHAR, 11'(CH_BS)));
    send_item(make_item(ACT_CHAR, 11'h41));
    send_item(make_item(ACT_CHAR, 11'(CH_TAB)));
    send_item(make_item(ACT_CHAR, 11'(CH_CR)));
    send_item(make_item(ACT_REFRESH, 11'd0));
    send_item(make_item(ACT_READ, 11'(COLUMNS - 1)));
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    hold_requests <= hold_requests + 1;
    repeat (12) send_item(make_item(ACT_CHAR, 11'(pick_char())));
    wait_drained();
  endtask

  task automatic test_random_traffic(int unsigned beats);
    int unsigned stop_at;
    int unsigned code;
    int base;
    stop_at = items_sent + beats;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 20))
          send_item(make_item(ACT_CHAR, 11'(pick_char())));
        4: begin
          // long tab runs can reach the right margin and wrap
          repeat ($urandom_range(6, 12)) begin
            send_item(make_item(ACT_CHAR, 11'(CH_TAB)));
            if ($urandom_range(0, 2) == 0)
              send_item(make_item(ACT_CHAR, 11'($urandom_range(32, 126))));
          end
        end
        5: repeat ($urandom_range(2, 8)) send_item(make_item(ACT_CHAR, 11'(CH_LF)));
        6: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 4))
              0: code = $urandom_range(0, 255);
              1: code = $urandom_range(SGR_FG_LO, SGR_FG_HI);
              2: code = $urandom_range(SGR_BG_LO, SGR_BG_HI);
              3: code = $urandom_range(0, 1) ? SGR_REVERSE : SGR_BOLD;
              default: code = $urandom_range(0, 50);
            endcase
            send_item(make_item(ACT_ATTR, 11'(code)));
          end
        end
        7: begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) begin
              base = int'(cur_row * COLUMNS + cur_col) - int'($urandom_range(0, 20));
              if (base < 0) base = 0;
            end else begin
              base = $urandom_range(0, 2047);
            end
            send_item(make_item(ACT_READ, 11'(base)));
          end
        end
        8: repeat ($urandom_range(1, 3))
          send_item(make_item(action_t'($urandom_range(0, 3)), 11'($urandom_range(0, 2047))));
        default: begin
          wait_drained();
          send_item(make_item(ACT_REFRESH, 11'd0));
        end
      endcase
    end
  endtask

  task automatic test_steady_stream(int unsigned beats);
    idling_on <= 1'b0;
    repeat (beats) begin
      if ($urandom_range(0, 5) == 0)
        send_item(make_item(ACT_READ, 11'($urandom_range(0, CELLS - 1))));
      else
        send_item(make_item(ACT_CHAR, 11'(pick_char())));
    end
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < CELLS; i++) screen_model[i] = {RESET_ATTR, BLANK_CHAR};
    cur_col = 0;
    cur_row = 0;
    cur_attr = RESET_ATTR;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_screen();
    test_attribute_codes();
    test_control_chars();
    test_output_backpressure();
    test_random_traffic(90);
    test_steady_stream(30);

    wait_drained();
    repeat (50) @(posedge clk);
    $display("sent %0d beats: %0d scrolls, %0d in-range cell reads, %0d bells",
             items_sent, scroll_count, read_count, bell_count);
    $display("checked %0d result beats, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("text_console_cell_writer_unit_test OK");
    end else begin
      $display("text_console_cell_writer_unit_test NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_ram.sv
rtl/text_console_cell_writer_unit.sv
rtl/tccw_checker.sv
tb/text_console_cell_writer_unit_test.sv
